// File: hw/rtl/necir_pkg.sv
// ----------------------------------------------------------------------------
// necir_pkg
// Shared types, register indexes and constants of the NEC IR edge decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package necir_pkg;

  localparam int FRAME_BITS = 32;
  localparam int CNT_W      = $clog2(FRAME_BITS) + 1;
  localparam int BIT_IDX_W  = $clog2(FRAME_BITS);

  // Register indexes on the configuration channel
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_ONE_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_MIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_WIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_FILTER  = 3'd5;

  // Reset values
  localparam logic [15:0] RST_FRAME_START = 16'd12000;
  localparam logic [15:0] RST_REPEAT_MIN  = 16'd9000;
  localparam logic [15:0] RST_BIT_ONE_MIN = 16'd1600;
  localparam logic [15:0] RST_BIT_MIN     = 16'd500;
  localparam logic [15:0] RST_REPEAT_WIN  = 16'd250;
  localparam logic [7:0]  ADDR_ANY        = 8'hFF;

  // Event kinds on tuser
  localparam logic KIND_FRAME  = 1'b0;
  localparam logic KIND_REPEAT = 1'b1;

  // Microseconds to milliseconds: floor(t / 1000) == (t * MS_RECIP) >> MS_SHIFT
  // for every 32-bit t.
  localparam int          RECIP_W  = 29;
  localparam logic [28:0] MS_RECIP = 29'h10624DD3;
  localparam int          MS_SHIFT = 38;
  localparam int          PROD_W   = 32 + RECIP_W;
  localparam int          MS_W     = PROD_W - MS_SHIFT;

  typedef struct packed {
    logic [15:0] frame_start_us;
    logic [15:0] repeat_min_us;
    logic [15:0] bit_one_min_us;
    logic [15:0] bit_min_us;
    logic [15:0] repeat_window_ms;
    logic [7:0]  address_filter;
  } cfg_t;

  typedef struct packed {
    logic [31:0]     now_us;
    logic [MS_W-1:0] now_ms;
  } edge_t;

endpackage

`default_nettype wire

// File: hw/rtl/nec_ir_edge_decoder.sv
// ----------------------------------------------------------------------------
// nec_ir_edge_decoder
// NEC infrared decoder fed with timestamped falling edges of the receiver.
// ----------------------------------------------------------------------------
//  channel   direction  tdata / payload                      tuser
//  s_axis    in         [31:0] edge_time_us                  -
//  m_axis    out        [7:0] command_code, [39:8] repeat_total  [0] event_kind
//  cfg       in         cfg_index (register), cfg_data [15:0]    -
//
//  An edge is taken every cycle while back-pressure allows; its result, if any, is
//  registered through the input register, reciprocal multiply and decode step.
//  The 32x29 reciprocal multiply for the millisecond time sets the stage depth.
//  A stalled result holds in the output register while the two earlier
//  stages keep filling; back-pressure reaches s_axis_tready once they are full.
//  Reset clears the valid flags and decoder state and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module nec_ir_edge_decoder
  import necir_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,   // [31:0] edge_time_us
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [39:0]          m_axis_tdata,   // [7:0] command_code, [39:8] repeat_total
  output logic                 m_axis_tuser,   // [0] event_kind
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  cfg_t        cfg;
  logic        edge_valid;
  logic        edge_ready;
  edge_t       edge_word;
  logic [7:0]  cmd;
  logic [31:0] total;

  necir_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  necir_ms_conv u_ms (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_time   (s_axis_tdata),
    .out_valid (edge_valid),
    .out_ready (edge_ready),
    .out_edge  (edge_word)
  );

  necir_frame_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (edge_valid),
    .in_ready  (edge_ready),
    .in_edge   (edge_word),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_cmd   (cmd),
    .out_total (total)
  );

  assign m_axis_tdata = {total, cmd};

endmodule

`default_nettype wire

// File: hw/rtl/necir_cfg_regs.sv
// ----------------------------------------------------------------------------
// necir_cfg_regs
// Configuration register file, written one word at a time by index.
// ----------------------------------------------------------------------------
`default_nettype none

module necir_cfg_regs
  import necir_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_start_us   <= RST_FRAME_START;
      cfg.repeat_min_us    <= RST_REPEAT_MIN;
      cfg.bit_one_min_us   <= RST_BIT_ONE_MIN;
      cfg.bit_min_us       <= RST_BIT_MIN;
      cfg.repeat_window_ms <= RST_REPEAT_WIN;
      cfg.address_filter   <= ADDR_ANY;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_START: cfg.frame_start_us   <= cfg_data;
        REG_REPEAT_MIN:  cfg.repeat_min_us    <= cfg_data;
        REG_BIT_ONE_MIN: cfg.bit_one_min_us   <= cfg_data;
        REG_BIT_MIN:     cfg.bit_min_us       <= cfg_data;
        REG_REPEAT_WIN:  cfg.repeat_window_ms <= cfg_data;
        REG_ADDR_FILTER: cfg.address_filter   <= cfg_data[7:0];
        default: begin
          // unmapped index: drop the word
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/necir_ms_conv.sv
// ----------------------------------------------------------------------------
// necir_ms_conv
// Input register and reciprocal multiply giving the edge time in milliseconds.
// ----------------------------------------------------------------------------
`default_nettype none

module necir_ms_conv
  import necir_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_time,
  output logic        out_valid,
  input  logic        out_ready,
  output edge_t       out_edge
);

  logic              a_valid;
  logic [31:0]       a_time;
  logic              b_ready;
  logic [PROD_W-1:0] prod;

  assign b_ready  = !out_valid || out_ready;
  assign in_ready = !a_valid || b_ready;
  assign prod     = {{RECIP_W{1'b0}}, a_time} * {{32{1'b0}}, MS_RECIP};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (b_ready) begin
        out_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_time <= in_time;
    end
    if (b_ready && a_valid) begin
      out_edge.now_us <= a_time;
      out_edge.now_ms <= prod[PROD_W-1:MS_SHIFT];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/necir_frame_fsm.sv
// ----------------------------------------------------------------------------
// necir_frame_fsm
// Gap classification, bit assembly, frame check and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module necir_frame_fsm
  import necir_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  edge_t       in_edge,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_cmd,
  output logic [31:0] out_total
);

  // decoder state
  logic [31:0]      prev_edge;
  logic [31:0]      shift_bits;
  logic [CNT_W-1:0] bits_rcvd;
  logic             frame_open;
  logic [7:0]       last_cmd;
  logic [31:0]      repeat_cnt;
  logic [MS_W-1:0]  last_ms;

  logic [31:0]      prev_edge_next;
  logic [31:0]      shift_bits_next;
  logic [CNT_W-1:0] bits_rcvd_next;
  logic             frame_open_next;
  logic [7:0]       last_cmd_next;
  logic [31:0]      repeat_cnt_next;
  logic [MS_W-1:0]  last_ms_next;

  logic             emit;
  logic             emit_kind;
  logic [7:0]       emit_cmd;
  logic [31:0]      emit_total;

  logic        go;
  logic [31:0] gap;
  logic        gap_hi;
  logic        ge_frame, ge_repeat, ge_one, ge_bit;
  logic [31:0] ms_diff;
  logic        in_window;
  logic [31:0] shifted;
  logic [CNT_W-1:0] bits_inc;
  logic        addr_ok, cmd_ok;

  assign in_ready = !out_valid || out_ready;
  assign go       = in_valid && in_ready;

  assign gap       = in_edge.now_us - prev_edge;
  assign gap_hi    = |gap[31:16];
  assign ge_frame  = gap_hi || (gap[15:0] >= cfg.frame_start_us);
  assign ge_repeat = gap_hi || (gap[15:0] >= cfg.repeat_min_us);
  assign ge_one    = gap_hi || (gap[15:0] >= cfg.bit_one_min_us);
  assign ge_bit    = gap_hi || (gap[15:0] >= cfg.bit_min_us);

  // millisecond difference wraps at 2^32
  assign ms_diff   = {{(32-MS_W){1'b0}}, in_edge.now_ms} - {{(32-MS_W){1'b0}}, last_ms};
  assign in_window = !(|ms_diff[31:16]) && (ms_diff[15:0] < cfg.repeat_window_ms);

  assign shifted  = shift_bits | ({31'b0, ge_one} << bits_rcvd[BIT_IDX_W-1:0]);
  assign bits_inc = bits_rcvd + 1'b1;
  assign addr_ok  = (cfg.address_filter == ADDR_ANY) || (shifted[7:0] == cfg.address_filter);
  assign cmd_ok   = (shifted[23:16] ^ shifted[31:24]) == 8'hFF;

  always_comb begin
    prev_edge_next  = prev_edge;
    shift_bits_next = shift_bits;
    bits_rcvd_next  = bits_rcvd;
    frame_open_next = frame_open;
    last_cmd_next   = last_cmd;
    repeat_cnt_next = repeat_cnt;
    last_ms_next    = last_ms;
    emit            = 1'b0;
    emit_kind       = KIND_FRAME;
    emit_cmd        = last_cmd;
    emit_total      = repeat_cnt;

    if (go) begin
      prev_edge_next = in_edge.now_us;
      if (ge_frame) begin
        shift_bits_next = '0;
        bits_rcvd_next  = '0;
        frame_open_next = 1'b1;
      end else if (ge_repeat) begin
        frame_open_next = 1'b0;
        if (in_window) begin
          repeat_cnt_next = repeat_cnt + 32'd1;
          last_ms_next    = in_edge.now_ms;
          emit            = 1'b1;
          emit_kind       = KIND_REPEAT;
          emit_cmd        = last_cmd;
          emit_total      = repeat_cnt + 32'd1;
        end
      end else if (frame_open && ge_bit) begin
        shift_bits_next = shifted;
        bits_rcvd_next  = bits_inc;
        // full frame: check address and command, then close
        if (bits_inc[CNT_W-1]) begin
          frame_open_next = 1'b0;
          if (addr_ok && cmd_ok) begin
            last_cmd_next   = shifted[23:16];
            repeat_cnt_next = '0;
            last_ms_next    = in_edge.now_ms;
            emit            = 1'b1;
            emit_kind       = KIND_FRAME;
            emit_cmd        = shifted[23:16];
            emit_total      = '0;
          end
        end
      end else begin
        frame_open_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_edge  <= '0;
      shift_bits <= '0;
      bits_rcvd  <= '0;
      frame_open <= 1'b0;
      last_cmd   <= '0;
      repeat_cnt <= '0;
      last_ms    <= '0;
      out_valid  <= 1'b0;
    end else begin
      prev_edge  <= prev_edge_next;
      shift_bits <= shift_bits_next;
      bits_rcvd  <= bits_rcvd_next;
      frame_open <= frame_open_next;
      last_cmd   <= last_cmd_next;
      repeat_cnt <= repeat_cnt_next;
      last_ms    <= last_ms_next;
      out_valid  <= (out_valid && !out_ready) || emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind  <= emit_kind;
      out_cmd   <= emit_cmd;
      out_total <= emit_total;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/necir_checker.sv
// ----------------------------------------------------------------------------
// necir_checker
// Port-level checks of the NEC IR edge decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module necir_checker
  import necir_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // nothing comes out of reset pending
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result pending right after reset");

  // a new frame always reports a cleared repeat count
  a_frame_total: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_FRAME) |-> m_axis_tdata[39:8] == 32'd0)
    else $error("new frame with non-zero repeat total");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // a rising result needs an earlier accepted edge, with allowance for stalls and reset
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 3)
      || $past(s_axis_tvalid && s_axis_tready, 4) || !$past(s_axis_tready, 1)
      || !$past(s_axis_tready, 2) || !$past(s_axis_tready, 3)
      || $past(rst, 3) || $past(rst, 4) || $past(s_axis_tvalid, 5))
    else $error("result without a preceding edge");

endmodule

bind nec_ir_edge_decoder necir_checker u_necir_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
